// ===== hw/rtl/mmc1_pkg.sv =====
// Shared types and constants for the MMC1 bank mapper.
package mmc1_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] cpu_address;
    logic [7:0]  write_data;
    logic [12:0] pattern_address;
  } req_t;

  typedef struct packed {
    logic [18:0] prg_rom_address;
    logic        prg_valid;
    logic [16:0] chr_rom_address;
    logic        chr_valid;
    logic        vertical_mirroring;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_APPLY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_req;
    logic start_mod;
    logic apply_write;
    logic load_res;
  } cmd_t;

  typedef struct packed {
    logic mod_busy;
    logic res_free;
  } stat_t;

  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_PATTERN = 2'd2;

  localparam logic [1:0] CFG_MAPPER_MODE = 2'd0;
  localparam logic [1:0] CFG_PRG_BANKS   = 2'd1;
  localparam logic [1:0] CFG_CHR_BANKS   = 2'd2;

  localparam logic [1:0] REG_CONTROL  = 2'd0;
  localparam logic [1:0] REG_CHR_LOW  = 2'd1;
  localparam logic [1:0] REG_CHR_HIGH = 2'd2;
  localparam logic [1:0] REG_PRG      = 2'd3;

  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;
  localparam logic [1:0] MIRROR_VERTICAL    = 2'd2;

  localparam logic [4:0] SHIFT_RESET   = 5'h10;
  localparam logic [4:0] CONTROL_RESET = 5'h0C;
  localparam logic [4:0] CONTROL_LOAD_RESET_BITS = 5'h0C;
  localparam logic [4:0] PRG_32K_MASK  = 5'h0E;

  localparam logic [5:0] PRG_BANKS_RESET = 6'd8;
  localparam logic [5:0] CHR_BANKS_RESET = 6'd8;

endpackage

// ===== hw/rtl/mmc1_mod.sv =====
// Bit-serial remainder unit: 5-bit bank number modulo a bank count.
module mmc1_mod (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [4:0] dividend,
  input  logic [5:0] divisor,
  output logic       busy,
  output logic [4:0] remainder
);
  logic [4:0] dvd;
  logic [5:0] dvs;
  logic [4:0] rem;
  logic [2:0] steps;
  logic [5:0] rem_sh;
  logic [5:0] rem_next;

  assign rem_sh    = {rem, dvd[4]};
  assign rem_next  = (rem_sh >= dvs) ? (rem_sh - dvs) : rem_sh;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= 3'd5;
    end else if (busy) begin
      steps <= steps - 3'd1;
      if (steps == 3'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[3:0], 1'b0};
      rem <= rem_next[4:0];
    end
  end

endmodule

// ===== hw/rtl/mmc1_dp.sv =====
// Datapath: configuration, serial load registers, bank remainder and result register.
module mmc1_dp #(
  parameter int MAX_PRG_BANKS    = 32,
  parameter int MAX_CHR_BANKS_4K = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [5:0]    cfg_data,
  input  mmc1_pkg::req_t req_data,
  input  mmc1_pkg::cmd_t cmd,
  output mmc1_pkg::stat_t stat,
  output logic          res_valid,
  input  logic          res_stall,
  output mmc1_pkg::res_t res_data
);
  import mmc1_pkg::*;

  logic       mapper_mode;
  logic [5:0] prg_banks;
  logic [5:0] chr_banks_4k;

  logic [4:0] serial_shift;
  logic [4:0] control_reg;
  logic [4:0] chr_bank_low;
  logic [4:0] chr_bank_high;
  logic [4:0] prg_bank_reg;

  req_t cur;

  logic [5:0] prg_n;
  logic [5:0] chr_n;
  logic [5:0] cnt8;
  logic [1:0] prg_layout;
  logic [4:0] mod_x;
  logic [5:0] mod_d;
  logic       mod_busy;
  logic [4:0] rem;
  logic [4:0] shifted;
  logic [14:0] off15;
  logic [5:0] bank32;
  logic [4:0] prg_bank;
  logic [16:0] chr_a;
  res_t       res_next;

  assign prg_n = (prg_banks > 6'(MAX_PRG_BANKS)) ? 6'(MAX_PRG_BANKS) : prg_banks;
  assign chr_n = (chr_banks_4k > 6'(MAX_CHR_BANKS_4K)) ? 6'(MAX_CHR_BANKS_4K) : chr_banks_4k;
  assign cnt8  = ((chr_n >> 1) == 6'd0) ? 6'd1 : (chr_n >> 1);
  assign prg_layout = control_reg[3:2];
  assign off15 = cur.cpu_address[14:0];
  assign shifted = {cur.write_data[0], serial_shift[4:1]};

  always_comb begin
    if (cur.func == FUNC_PATTERN) begin
      if (!control_reg[4]) begin
        mod_x = chr_bank_low >> 1;
        mod_d = cnt8;
      end else begin
        mod_x = cur.pattern_address[12] ? chr_bank_high : chr_bank_low;
        mod_d = chr_n;
      end
    end else begin
      mod_x = (prg_layout inside {PRG_MODE_FIX_FIRST, PRG_MODE_FIX_LAST}) ?
              prg_bank_reg : (prg_bank_reg & PRG_32K_MASK);
      mod_d = prg_n;
    end
  end

  mmc1_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start_mod),
    .dividend  (mod_x),
    .divisor   (mod_d),
    .busy      (mod_busy),
    .remainder (rem)
  );

  assign stat.mod_busy = mod_busy;
  assign stat.res_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapper_mode  <= 1'b1;
      prg_banks    <= PRG_BANKS_RESET;
      chr_banks_4k <= CHR_BANKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAPPER_MODE: mapper_mode  <= cfg_data[0];
        CFG_PRG_BANKS:   prg_banks    <= cfg_data;
        CFG_CHR_BANKS:   chr_banks_4k <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cur <= req_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_shift  <= SHIFT_RESET;
      control_reg   <= CONTROL_RESET;
      chr_bank_low  <= '0;
      chr_bank_high <= '0;
      prg_bank_reg  <= '0;
    end else if (cmd.apply_write && cur.func == FUNC_WRITE && mapper_mode) begin
      if (cur.write_data[7]) begin
        serial_shift <= SHIFT_RESET;
        control_reg  <= control_reg | CONTROL_LOAD_RESET_BITS;
      end else if (serial_shift[0]) begin
        serial_shift <= SHIFT_RESET;
        case (cur.cpu_address[14:13])
          REG_CONTROL:  control_reg   <= shifted;
          REG_CHR_LOW:  chr_bank_low  <= shifted;
          REG_CHR_HIGH: chr_bank_high <= shifted;
          REG_PRG:      prg_bank_reg  <= shifted;
          default: ;
        endcase
      end else begin
        serial_shift <= shifted;
      end
    end
  end

  // 32K mode: bank plus the half select, wrapped once
  always_comb begin
    bank32 = {1'b0, rem} + {5'd0, off15[14]};
    if (bank32 >= prg_n) begin
      bank32 = bank32 - prg_n;
    end
  end

  always_comb begin
    if (!off15[14]) begin
      prg_bank = (prg_layout == PRG_MODE_FIX_FIRST) ? 5'd0 : rem;
    end else begin
      prg_bank = (prg_layout == PRG_MODE_FIX_FIRST) ? rem : 5'(prg_n - 6'd1);
    end
  end

  always_comb begin
    if (!mapper_mode) begin
      chr_a = {4'd0, cur.pattern_address};
    end else if (!control_reg[4]) begin
      chr_a = {rem[3:0], cur.pattern_address};
    end else begin
      chr_a = {rem, cur.pattern_address[11:0]};
    end
  end

  always_comb begin
    res_next = '0;
    res_next.vertical_mirroring = (control_reg[1:0] == MIRROR_VERTICAL);
    case (cur.func)
      FUNC_READ: begin
        if (prg_n != 6'd0) begin
          res_next.prg_valid = 1'b1;
          if (!mapper_mode) begin
            res_next.prg_rom_address = {4'd0, off15[14] & (prg_n != 6'd1), off15[13:0]};
          end else if (prg_layout inside {PRG_MODE_FIX_FIRST, PRG_MODE_FIX_LAST}) begin
            res_next.prg_rom_address = {prg_bank, off15[13:0]};
          end else begin
            res_next.prg_rom_address = {bank32[4:0], off15[13:0]};
          end
        end
      end
      FUNC_PATTERN: begin
        if (chr_n == 6'd0) begin
          res_next.chr_rom_address = {4'd0, cur.pattern_address};
        end else begin
          res_next.chr_rom_address = chr_a;
          res_next.chr_valid = ({1'b0, chr_a[16:12]} < chr_n);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      res_data <= res_next;
    end
  end

endmodule

// ===== hw/rtl/mmc1_ctrl.sv =====
// Controller: sequences one request through remainder, register update and result load.
module mmc1_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  mmc1_pkg::stat_t stat,
  output mmc1_pkg::cmd_t  cmd
);
  import mmc1_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_START;
        end
      end
      ST_START: state_next = ST_WAIT;
      ST_WAIT: begin
        if (!stat.mod_busy) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: state_next = ST_OUT;
      ST_OUT: begin
        if (stat.res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        req_stall    = 1'b0;
        cmd.load_req = req_valid;
      end
      ST_START: cmd.start_mod   = 1'b1;
      ST_APPLY: cmd.apply_write = 1'b1;
      ST_OUT:   cmd.load_res    = stat.res_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/mmc1_bank_mapper.sv =====
// MMC1 bank mapper top level: controller plus datapath.
// The controller takes each request from acceptance to its result through the
// start state, the wait on the bit-serial bank remainder unit, the serial load
// register update and the result register load, and only then returns to idle
// to accept the next request. A finished result waits in the result register
// while the next request is accepted and processed; the controller holds in
// its last state only if the previous result is still stalled at that point.
// Configuration (mapper mode, bank counts) is written through the cfg port;
// the user must write it only while the block is idle, as the block does not
// enforce this. Bank counts above the maximum parameters saturate.
module mmc1_bank_mapper #(
  parameter int MAX_PRG_BANKS    = 32,
  parameter int MAX_CHR_BANKS_4K = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [1:0]     cfg_index,
  input  logic [5:0]     cfg_data,
  input  logic           req_valid,
  output logic           req_stall,
  input  mmc1_pkg::req_t req_data,
  output logic           res_valid,
  input  logic           res_stall,
  output mmc1_pkg::res_t res_data
);
  import mmc1_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mmc1_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mmc1_dp #(
    .MAX_PRG_BANKS    (MAX_PRG_BANKS),
    .MAX_CHR_BANKS_4K (MAX_CHR_BANKS_4K)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule
